// File: src/mexp_pkg.sv
// Package for the modular exponentiation core: field widths, register map,
// and the control/status structs exchanged with the serial multiplier.
// No dependencies.
`default_nettype none

package mexp_pkg;

  // Exponent bits scanned and modulus bits kept.
  localparam int EXP_BITS = 63;
  localparam int MOD_BITS = 31;

  // Fixed widths of the payload fields.
  localparam int BASE_W = 31;
  localparam int EXP_W  = 63;
  localparam int RES_W  = 31;

  // Bit counter of the serial multiplier.
  localparam int CNT_W = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;

  // APB register map: one 32-bit register per word.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_IDX_MODULUS = 1'b0;

  localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(1000000007);

  typedef struct packed {
    logic start;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage

`default_nettype wire

// File: src/mexp_if.sv
// Valid/ready channel interfaces for the operand and result transfers.
// Depends on mexp_pkg for the field widths.
`default_nettype none

interface mexp_in_if import mexp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] base_value;
  logic [EXP_W-1:0]  exponent;

  modport source (output valid, output base_value, output exponent, input ready);
  modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

`default_nettype wire

// File: src/mexp_mul.sv
// Bit-serial modular multiplier: product = a * b mod m, one bit of b per cycle.
// Depends on mexp_pkg. Requires a < m; b may take any value.
`default_nettype none

module mexp_mul import mexp_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mul_req_t            req,
  input  wire logic [MOD_BITS-1:0] a,
  input  wire logic [MOD_BITS-1:0] b,
  input  wire logic [MOD_BITS-1:0] m,
  output mul_sts_t                 sts,
  output logic      [MOD_BITS-1:0] product
);

  logic                busy;
  logic                done;
  logic [CNT_W-1:0]    cnt;
  logic [MOD_BITS-1:0] a_q;
  logic [MOD_BITS-1:0] m_q;
  logic [MOD_BITS-1:0] b_sh;
  logic [MOD_BITS-1:0] r;

  logic [MOD_BITS:0]   dbl;
  logic [MOD_BITS-1:0] dbl_red;
  logic [MOD_BITS:0]   sum;
  logic [MOD_BITS-1:0] r_next;

  // Horner step, MSB of b first: r = (2r mod m + bit*a) mod m.
  always_comb begin
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= {1'b0, m_q}) ? MOD_BITS'(dbl - {1'b0, m_q}) : MOD_BITS'(dbl);
    sum     = {1'b0, dbl_red} + {1'b0, (b_sh[MOD_BITS-1] ? a_q : '0)};
    r_next  = (sum >= {1'b0, m_q}) ? MOD_BITS'(sum - {1'b0, m_q}) : MOD_BITS'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // The completion pulse follows the step on the last bit.
      done <= !req.start && busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MOD_BITS - 1);
        a_q  <= a;
        m_q  <= m;
        b_sh <= b;
        r    <= '0;
      end else if (busy) begin
        r    <= r_next;
        b_sh <= b_sh << 1;
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign product  = r;

endmodule

`default_nettype wire

// File: src/modular_exponentiation_core.sv
// Top level of the modular exponentiation core: APB modulus register, control
// sequencer and result register. Depends on mexp_pkg, mexp_if and mexp_mul.
// Channel table:
//   port      kind         direction  payload
//   operands  valid/ready  in         base_value[30:0], exponent[62:0]
//   result    valid/ready  out        power_result[30:0]
//   APB       psel/penable in         modulus at byte address 0
//
// Multiplications: an item with a zero exponent needs none. Any
// other item takes 1 + popcount(e) + floor(log2(e)) multiplications, at most
// 126, all on the single shared bit-serial multiplier, which handles one bit
// of the multiplier operand per cycle. Reset is synchronous and loads the
// modulus 1000000007. A stalled result holds in its output register; the core
// finishes its current item behind it and accepts the next once it is back in
// idle.
`default_nettype none

module modular_exponentiation_core import mexp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  mexp_in_if.sink                    operands,
  mexp_out_if.source                 result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  // One-hot sequencer. REDUCE brings the base below the modulus, ACC folds
  // the current power into the accumulator, SQR squares the power.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_ACC    = 5'b00100,
    S_SQR    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t              state;
  logic [MOD_BITS-1:0] modulus;
  logic [MOD_BITS-1:0] m_eff;
  logic [MOD_BITS-1:0] one_mod;
  logic [MOD_BITS-1:0] pw;
  logic [MOD_BITS-1:0] acc;
  logic [EXP_BITS-1:0] e_reg;
  logic [EXP_BITS-1:0] e_rest;
  logic [MOD_BITS-1:0] power_q;
  logic                result_valid;
  logic                mul_start;
  logic                mul_start_next;
  logic                cfg_write;
  logic                in_take;

  mul_req_t            mul_req;
  mul_sts_t            mul_sts;
  logic [MOD_BITS-1:0] mul_a;
  logic [MOD_BITS-1:0] mul_b;
  logic [MOD_BITS-1:0] mul_res;

  // A modulus of zero behaves as a modulus of one. The reduction pass
  // multiplies the raw base by one, which itself must be reduced first.
  assign m_eff   = (modulus == '0) ? MOD_BITS'(1) : modulus;
  assign one_mod = (m_eff == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
  assign e_rest  = e_reg >> 1;

  // APB: the write lands in the access cycle; pready is tied high.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_IDX_MODULUS) ? APB_DATA_W'(modulus) : '0;

  assign operands.ready = (state == S_IDLE);
  assign in_take        = operands.valid && operands.ready;

  // Multiplier operands: both come from held registers, so they are stable
  // at the cycle the start pulse is registered.
  assign mul_a         = (state == S_REDUCE) ? one_mod : pw;
  assign mul_b         = (state == S_ACC) ? acc : pw;
  assign mul_req.start = mul_start;

  // A multiplication is launched on a nonzero exponent and after every
  // completion, except the accumulation that consumes the last set bit.
  always_comb begin
    unique case (state)
      S_IDLE:   mul_start_next = in_take && (operands.exponent[EXP_BITS-1:0] != '0);
      S_REDUCE: mul_start_next = mul_sts.done;
      S_ACC:    mul_start_next = mul_sts.done && (e_rest != '0);
      S_SQR:    mul_start_next = mul_sts.done;
      S_FINISH: mul_start_next = 1'b0;
      default:  mul_start_next = 1'b0;
    endcase
  end

  mexp_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .a       (mul_a),
    .b       (mul_b),
    .m       (m_eff),
    .sts     (mul_sts),
    .product (mul_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mul_start    <= 1'b0;
      result_valid <= 1'b0;
      modulus      <= MOD_RESET;
    end else begin
      mul_start <= mul_start_next;
      if (cfg_write && paddr[2] == REG_IDX_MODULUS) begin
        modulus <= pwdata[MOD_BITS-1:0];
      end
      // In the finishing state the output register is handled below.
      if (result.valid && result.ready && state != S_FINISH) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            pw    <= operands.base_value[MOD_BITS-1:0];
            e_reg <= operands.exponent[EXP_BITS-1:0];
            acc   <= MOD_BITS'(1);
            // A zero exponent yields one, whatever the modulus.
            if (operands.exponent[EXP_BITS-1:0] == '0) begin
              state <= S_FINISH;
            end else begin
              state <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (mul_sts.done) begin
            pw    <= mul_res;
            state <= e_reg[0] ? S_ACC : S_SQR;
          end
        end
        S_ACC: begin
          if (mul_sts.done) begin
            acc <= mul_res;
            // Once no set bits remain, further squarings cannot matter.
            if (e_rest == '0) begin
              state <= S_FINISH;
            end else begin
              state <= S_SQR;
            end
          end
        end
        S_SQR: begin
          if (mul_sts.done) begin
            pw    <= mul_res;
            e_reg <= e_rest;
            state <= e_rest[0] ? S_ACC : S_SQR;
          end
        end
        S_FINISH: begin
          if (!result_valid || result.ready) begin
            result_valid <= 1'b1;
            power_q      <= acc;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid        = result_valid;
  assign result.power_result = RES_W'(power_q);

  // A new multiplication is never requested while one is still running.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_sts.busy |-> !mul_req.start)
    else $error("multiplier started while busy");

  // Completions only arrive while the sequencer waits for one.
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_sts.done |-> (state == S_REDUCE || state == S_ACC || state == S_SQR))
    else $error("multiplier completion outside a multiply state");

  // A squaring is only spent when a set exponent bit is still ahead.
  a_sqr_needed: assert property (@(posedge clk) disable iff (rst)
    state == S_SQR |-> e_rest != '0)
    else $error("squaring with no remaining exponent bits");

  // A new result is only raised from the finishing state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == S_FINISH))
    else $error("result raised outside the finishing state");

endmodule

`default_nettype wire
